### rtl/rau_pkg.sv
// Package: payload types and result codes for the rational arithmetic unit.
package rau_pkg;

  typedef struct packed {
    logic signed [31:0] num_a;
    logic [30:0]        den_a;
    logic signed [31:0] num_b;
    logic [30:0]        den_b;
  } rau_in_t;

  typedef struct packed {
    logic [2:0]         which;
    logic signed [63:0] whole;
    logic signed [63:0] part_num;
    logic [62:0]        part_den;
    logic               infinite;
    logic               last;
  } rau_out_t;

  localparam logic [2:0] WHICH_A    = 3'd0;
  localparam logic [2:0] WHICH_B    = 3'd1;
  localparam logic [2:0] WHICH_SUM  = 3'd2;
  localparam logic [2:0] WHICH_DIFF = 3'd3;
  localparam logic [2:0] WHICH_PROD = 3'd4;
  localparam logic [2:0] WHICH_QUOT = 3'd5;

endpackage

### rtl/rational_arithmetic_unit.sv
// Top level: iterative rational arithmetic with gcd reduction.
//
//  channel | ports                         | handshake
//  input   | start, busy, in_data          | taken when start && !busy
//  result  | out_valid, out_data           | one-cycle strobe, no backpressure
//
// One item gives six results; each value is reduced by Euclid steps (at least
// one each). All work runs through one 64-bit shift-subtract divider (one
// quotient bit per cycle, used for gcd steps, reduction and mixed form) and one
// 33x33 multiplier. Each gcd step is one divide; each value then takes three
// divides (numerator, denominator, mixed form).
// Reset (synchronous, rst_n low) returns the sequencer to idle.
// busy stays high from acceptance until the sixth result has been strobed.
module rational_arithmetic_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rau_pkg::rau_in_t  in_data,
  output logic              out_valid,
  output rau_pkg::rau_out_t out_data
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_MUL, S_SIGN, S_GCD, S_GDIV, S_DIVN, S_DIVD,
    S_MIX, S_EMIT, S_STORE
  } state_t;

  state_t state_r;
  logic [2:0] k_r;          // which value is being reduced
  logic [2:0] mstep_r;      // multiplier operand step in S_MUL and S_LOAD
  // reduced operands
  logic signed [31:0] na_r, nb_r;
  logic [30:0]        da_r, db_r;
  // current value n/d: sign and magnitudes
  logic               neg_r;
  logic [63:0]        nmag_r, dmag_r;
  logic [63:0]        gx_r, gy_r;
  logic               inf_r;
  // products
  logic signed [63:0] p0_r, p1_r;
  logic [63:0]        pd_r;
  // divider
  logic [63:0] dq_r, drem_r, ddiv_r;
  logic [6:0]  dcnt_r;
  logic        dbusy_r;

  // shared multiplier operand select
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  always_comb begin
    ma = '0; mb = '0;
    case (mstep_r)
      3'd0: begin ma = 33'(na_r); mb = $signed({2'b0, db_r}); end
      3'd1: begin ma = 33'(nb_r); mb = $signed({2'b0, da_r}); end
      3'd2: begin ma = $signed({2'b0, da_r}); mb = $signed({2'b0, db_r}); end
      3'd3: begin ma = 33'(na_r); mb = 33'(nb_r); end
      default: begin ma = $signed({2'b0, da_r}); mb = 33'(nb_r); end
    endcase
    mp = ma * mb;
  end

  // divider step: restoring, one quotient bit per cycle
  logic [64:0] trial;
  logic [63:0] rsh;
  always_comb begin
    rsh   = {drem_r[62:0], dq_r[63]};
    trial = {1'b0, rsh} - {1'b0, ddiv_r};
  end

  // value being reduced, selected by k
  logic signed [63:0] vn;
  logic signed [63:0] vd;
  always_comb begin
    vn = '0; vd = 64'sd1;
    case (k_r)
      WHICH_A:    begin vn = 64'(na_r); vd = $signed({33'b0, da_r}); end
      WHICH_B:    begin vn = 64'(nb_r); vd = $signed({33'b0, db_r}); end
      WHICH_SUM:  begin vn = p0_r + p1_r; vd = $signed(pd_r); end
      WHICH_DIFF: begin vn = p0_r - p1_r; vd = $signed(pd_r); end
      WHICH_PROD: begin vn = p1_r; vd = $signed(pd_r); end
      default:    begin vn = p0_r; vd = p1_r; end
    endcase
  end

  logic [63:0] vnm, vdm;
  assign vnm = vn[63] ? 64'(-vn) : vn;
  assign vdm = vd[63] ? 64'(-vd) : vd;

  logic signed [63:0] wsgn, rsgn;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      dbusy_r   <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            na_r    <= in_data.num_a;
            nb_r    <= in_data.num_b;
            da_r    <= (in_data.den_a == '0) ? 31'd1 : in_data.den_a;
            db_r    <= (in_data.den_b == '0) ? 31'd1 : in_data.den_b;
            k_r     <= WHICH_A;
            state_r <= S_SIGN;
          end
        end
        // form products for sum, difference, product, quotient
        S_MUL: begin
          mstep_r <= mstep_r + 3'd1;
          case (mstep_r)
            3'd0: p0_r <= mp[63:0];
            3'd1: p1_r <= mp[63:0];
            3'd2: pd_r <= mp[63:0];
            default: ;
          endcase
          if (mstep_r == 3'd2) begin
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          // pick per-result operands for quotient and product
          if (k_r == WHICH_PROD) begin
            p1_r    <= mp[63:0];
            mstep_r <= 3'd4;
          end else if (k_r == WHICH_QUOT) begin
            p1_r    <= mp[63:0];
          end
          state_r <= S_SIGN;
        end
        S_SIGN: begin
          inf_r  <= (k_r == WHICH_QUOT) && (nb_r == '0);
          neg_r  <= vn[63] ^ vd[63];
          nmag_r <= vnm;
          dmag_r <= vdm;
          gx_r   <= vnm;
          gy_r   <= vdm;
          if ((k_r == WHICH_QUOT) && (nb_r == '0)) begin
            nmag_r <= '0; dmag_r <= 64'd1; gx_r <= '0; gy_r <= 64'd1;
          end
          state_r <= S_GCD;
        end
        // Euclid: x mod y on the shared divider
        S_GCD: begin
          if (gy_r == '0) begin
            if (gx_r == '0) gx_r <= 64'd1;
            state_r <= S_DIVN;
            dbusy_r <= 1'b0;
          end else if (!dbusy_r) begin
            dq_r <= gx_r; drem_r <= '0; ddiv_r <= gy_r;
            dcnt_r <= 7'd64; dbusy_r <= 1'b1;
            state_r <= S_GDIV;
          end
        end
        S_GDIV: begin
          if (dcnt_r != '0) begin
            dcnt_r <= dcnt_r - 7'd1;
            dq_r   <= {dq_r[62:0], ~trial[64]};
            drem_r <= trial[64] ? rsh : trial[63:0];
          end else begin
            gx_r <= gy_r; gy_r <= drem_r;
            dbusy_r <= 1'b0;
            state_r <= S_GCD;
          end
        end
        // divide numerator, then denominator, by the gcd
        S_DIVN, S_DIVD: begin
          if (!dbusy_r) begin
            dq_r <= (state_r == S_DIVN) ? nmag_r : dmag_r;
            drem_r <= '0; ddiv_r <= gx_r;
            dcnt_r <= 7'd64; dbusy_r <= 1'b1;
          end else if (dcnt_r != '0) begin
            dcnt_r <= dcnt_r - 7'd1;
            dq_r   <= {dq_r[62:0], ~trial[64]};
            drem_r <= trial[64] ? rsh : trial[63:0];
          end else begin
            dbusy_r <= 1'b0;
            if (state_r == S_DIVN) begin
              nmag_r <= dq_r; state_r <= S_DIVD;
            end else begin
              dmag_r <= dq_r; state_r <= S_MIX;
            end
          end
        end
        // whole part and remainder of reduced n/d
        S_MIX: begin
          if (!dbusy_r) begin
            dq_r <= nmag_r; drem_r <= '0; ddiv_r <= dmag_r;
            dcnt_r <= 7'd64; dbusy_r <= 1'b1;
          end else if (dcnt_r != '0) begin
            dcnt_r <= dcnt_r - 7'd1;
            dq_r   <= {dq_r[62:0], ~trial[64]};
            drem_r <= trial[64] ? rsh : trial[63:0];
          end else begin
            dbusy_r <= 1'b0;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          out_valid <= 1'b1;
          out_data.which    <= k_r;
          out_data.whole    <= wsgn;
          out_data.part_num <= rsgn;
          out_data.part_den <= dmag_r[62:0];
          out_data.infinite <= inf_r;
          out_data.last     <= (k_r == WHICH_QUOT);
          state_r <= S_STORE;
        end
        S_STORE: begin
          if (k_r == WHICH_A) begin
            na_r <= 32'(neg_r ? -$signed(nmag_r) : $signed(nmag_r));
            da_r <= dmag_r[30:0];
            k_r  <= WHICH_B;
            state_r <= S_SIGN;
          end else if (k_r == WHICH_B) begin
            nb_r <= 32'(neg_r ? -$signed(nmag_r) : $signed(nmag_r));
            db_r <= dmag_r[30:0];
            k_r  <= WHICH_SUM;
            mstep_r <= 3'd0;
            state_r <= S_MUL;
          end else if (k_r == WHICH_QUOT) begin
            state_r <= S_IDLE;
          end else begin
            k_r <= k_r + 3'd1;
            if (k_r == WHICH_SUM) begin
              state_r <= S_SIGN;
            end else if (k_r == WHICH_DIFF) begin
              mstep_r <= 3'd3;
              state_r <= S_LOAD;
            end else begin
              // quotient: numerator na*db is p0, denominator da*nb
              mstep_r <= 3'd4;
              p0_r    <= p0_r;
              state_r <= S_LOAD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // signed whole part and remainder numerator from the divider outputs
  always_comb begin
    wsgn = neg_r ? 64'(-$signed(dq_r)) : $signed(dq_r);
    rsgn = (neg_r && (dq_r == '0)) ? 64'(-$signed(drem_r)) : $signed(drem_r);
  end

  assign busy = (state_r != S_IDLE);

  // a result only leaves while busy
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside a run");
  // reported denominator is never zero
  a_den_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.part_den != '0)) else $error("zero denominator");
  // infinite only on the quotient
  a_inf_q: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.infinite) |-> (out_data.which == WHICH_QUOT))
    else $error("infinite flag on non-quotient");
  // last result ends the run
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last) |=> !busy) else $error("run did not end");
endmodule

### tb/rational_arithmetic_unit_test.sv
// Testbench for the rational arithmetic unit: directed and random fractions, scoreboard check.
module rational_arithmetic_unit_test;
  import rau_pkg::*;

  // Predicts the six mixed-form results of each word and checks them in order.
  class fraction_scoreboard;
    rau_out_t expected_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function longint unsigned gcd(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      return x;
    endfunction

    // Reduce n/d so that d is positive and coprime with n.
    function void reduce(inout longint n, inout longint d);
      longint unsigned g;
      if (d < 0) begin
        n = -n;
        d = -d;
      end
      g = gcd(mag(n), 64'(d));
      if (g == 0) g = 1;
      n = n / longint'(g);
      d = d / longint'(g);
    endfunction

    function void push_mixed(logic [2:0] code, longint n, longint d, logic inf);
      rau_out_t r;
      longint w, rem;
      reduce(n, d);
      w = n / d;
      rem = n % d;
      if (w < 0) rem = -rem;
      r.which = code;
      r.whole = w;
      r.part_num = rem;
      r.part_den = d[62:0];
      r.infinite = inf;
      r.last = (code == WHICH_QUOT);
      expected_q.push_back(r);
    endfunction

    function void note_word(rau_in_t w);
      longint na, da, nb, db;
      na = longint'(w.num_a);
      da = (w.den_a == 0) ? 1 : longint'({1'b0, w.den_a});
      nb = longint'(w.num_b);
      db = (w.den_b == 0) ? 1 : longint'({1'b0, w.den_b});
      reduce(na, da);
      reduce(nb, db);
      push_mixed(WHICH_A, na, da, 1'b0);
      push_mixed(WHICH_B, nb, db, 1'b0);
      push_mixed(WHICH_SUM, na * db + nb * da, da * db, 1'b0);
      push_mixed(WHICH_DIFF, na * db - nb * da, da * db, 1'b0);
      push_mixed(WHICH_PROD, na * nb, da * db, 1'b0);
      if (nb == 0) push_mixed(WHICH_QUOT, 0, 1, 1'b1);
      else push_mixed(WHICH_QUOT, na * db, da * nb, 1'b0);
    endfunction

    function void check_result(rau_out_t got);
      rau_out_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result word which=%0d", got.which);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.which !== e.which) begin
        $error("which: expected %0d actual %0d", e.which, got.which); errors++;
      end
      if (got.whole !== e.whole) begin
        $error("whole: expected %0d actual %0d", e.whole, got.whole); errors++;
      end
      if (got.part_num !== e.part_num) begin
        $error("part_num: expected %0d actual %0d", e.part_num, got.part_num); errors++;
      end
      if (got.part_den !== e.part_den) begin
        $error("part_den: expected %0d actual %0d", e.part_den, got.part_den); errors++;
      end
      if (got.infinite !== e.infinite) begin
        $error("infinite: expected %0d actual %0d", e.infinite, got.infinite); errors++;
      end
      if (got.last !== e.last) begin
        $error("last: expected %0d actual %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  rau_in_t in_data = '0;
  logic out_valid;
  rau_out_t out_data;
  fraction_scoreboard sb = new();
  int unsigned idle_cycles = 0;

  rational_arithmetic_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Note accepted words, check strobed results, and watch for a stalled block.
  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_word(in_data);
    if (rst_n && out_valid) sb.check_result(out_data);
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 200000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one word after a random gap and hold it until accepted.
  task automatic send_word(rau_in_t w);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic send_fracs(logic [31:0] na, logic [30:0] da, logic [31:0] nb, logic [30:0] db);
    rau_in_t w;
    w.num_a = na;
    w.den_a = da;
    w.num_b = nb;
    w.den_b = db;
    send_word(w);
  endtask

  // Draw a numerator: mostly small, sometimes full width or zero.
  function automatic logic [31:0] pick_num();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 32'd0;
    if (k < 3) return $urandom;
    return 32'($signed($urandom_range(0, 2000)) - 1000);
  endfunction

  function automatic logic [30:0] pick_den();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return 31'd0;
    if (k < 5) return 31'($urandom);
    return 31'($urandom_range(1, 1000));
  endfunction

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, zero denominators, zero divisor, negative divisor.
    send_fracs(32'h7fffffff, 31'h7fffffff, 32'h80000000, 31'h7fffffff);
    send_fracs(32'h80000000, 31'd1, 32'h80000000, 31'd1);
    send_fracs(32'h7fffffff, 31'd1, 32'h7fffffff, 31'd1);
    send_fracs(32'h80000000, 31'h7fffffff, 32'h7fffffff, 31'd1);
    send_fracs(32'd5, 31'd0, 32'd3, 31'd0);
    send_fracs(32'd7, 31'd3, 32'd0, 31'd9);
    send_fracs(32'd0, 31'd5, 32'd0, 31'd0);
    send_fracs(-32'sd7, 31'd3, -32'sd2, 31'd5);
    send_fracs(32'd7, 31'd3, -32'sd2, 31'd5);
    send_fracs(-32'sd1, 31'd2, 32'd1, 31'd2);
    send_fracs(32'd6, 31'd4, 32'd9, 31'd6);
    send_fracs(32'd1, 31'd1, 32'd1, 31'd1);
    send_fracs(-32'sd10, 31'd5, 32'd4, 31'd2);
    send_fracs(32'h80000000, 31'h40000000, -32'sd1, 31'h7fffffff);
    send_fracs(32'h7fffffff, 31'h7ffffffe, 32'h7ffffffe, 31'h7fffffff);
    send_fracs(32'h55555555, 31'h2aaaaaaa, 32'haaaaaaaa, 31'h55555555);

    // Random words with random gaps, including back-to-back stretches.
    repeat (300) send_fracs(pick_num(), pick_den(), pick_num(), pick_den());
    start <= 1'b0;

    // Drain, then let trailing strobes show up.
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
